[rtl/sts_pkg.sv]
// Shared types and constants of the spike time scheduler.
`default_nettype none
package sts_pkg;

  localparam int NEURON_COUNT = 8;
  localparam int QUEUE_DEPTH  = 4;

  localparam int NIDX_W = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
  localparam int QH_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_DEPTH = NEURON_COUNT * QUEUE_DEPTH;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam int IDX_W   = 4;
  localparam int TIME_W  = 32;
  localparam int GROUP_W = 16;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam int FIRE_W  = 6;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_TICK = 1'b1
  } sts_cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK  = 2'd0,
    KIND_FIRE = 2'd1,
    KIND_DONE = 2'd2
  } sts_kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } sts_status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } sts_state_e;

  typedef struct packed {
    sts_cmd_e                 cmd;
    logic                     in_range;
    logic [IDX_W-1:0]         idx;
    logic [TIME_W-1:0]        time_val;
  } sts_req_t;

endpackage
`default_nettype wire

[rtl/spike_time_scheduler_top.sv]
// Top level of the spike time scheduler: front end, back end and APB register.
//
// Requests enter on start with command_i, neuron_index_i and time_value_i and
// are accepted at an edge with start high and busy low. A two-entry request
// queue decouples the front end from the back end, so busy rises only when
// both entries are taken.
// An add is executed by the back end while it is idle; its acknowledge passes
// through the request queue and the output register.
// A tick leaves the queue, then walks the neuron queues in index order, firing
// the due heads of each neuron in queue order before it moves on, and holds the
// back end until the walk ends. Each result is registered before it is shown.
// The neuron walk sets the throughput of ticks: no new request leaves the queue
// while a tick walks.
// Results are shown for one cycle with result_valid_o high; last_item_o marks
// the final result of a request. The receiver cannot stall the block.
// The group register lies at byte address 0 of the APB port and is copied
// onto every result. Reset empties all queues and clears the register.
`default_nettype none
module spike_time_scheduler_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command_i,
  input  wire logic [3:0]  neuron_index_i,
  input  wire logic [31:0] time_value_i,
  output logic             result_valid_o,
  output logic [1:0]       kind_o,
  output logic [15:0]      group_out_o,
  output logic [3:0]       fired_neuron_o,
  output logic [1:0]       status_o,
  output logic [5:0]       fire_count_o,
  output logic             last_item_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sts_pkg::*;

  logic               req_valid;
  sts_req_t           req;
  logic               req_pop;
  logic [GROUP_W-1:0] group_q;
  logic               reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == 1'b0);
  assign prdata  = reg_hit ? {16'd0, group_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      group_q <= pwdata[GROUP_W-1:0];
    end
  end

  sts_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .neuron_index_i (neuron_index_i),
    .time_value_i   (time_value_i),
    .req_valid_o    (req_valid),
    .req_o          (req),
    .req_pop_i      (req_pop)
  );

  sts_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid),
    .req_i          (req),
    .req_pop_o      (req_pop),
    .group_i        (group_q),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .group_out_o    (group_out_o),
    .fired_neuron_o (fired_neuron_o),
    .status_o       (status_o),
    .fire_count_o   (fire_count_o),
    .last_item_o    (last_item_o)
  );

endmodule
`default_nettype wire

[rtl/sts_front.sv]
// Front end: accepts requests, classifies them and buffers them in a small queue.
`default_nettype none
module sts_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  command_i,
  input  wire logic [3:0]            neuron_index_i,
  input  wire logic [31:0]           time_value_i,
  output logic                       req_valid_o,
  output sts_pkg::sts_req_t          req_o,
  input  wire logic                  req_pop_i
);
  import sts_pkg::*;

  sts_req_t   buf_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;
  sts_req_t   req_new;

  assign busy        = (cnt_q == 2'd2);
  assign push        = start && !busy;
  assign req_valid_o = (cnt_q != 2'd0);
  assign pop         = req_pop_i && req_valid_o;
  assign req_o       = buf_q[rd_ptr_q];

  always_comb begin
    req_new.cmd      = sts_cmd_e'(command_i);
    req_new.in_range = ({1'b0, neuron_index_i} < 5'(NEURON_COUNT));
    req_new.idx      = neuron_index_i;
    req_new.time_val = time_value_i;
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= req_new;
    end
  end

endmodule
`default_nettype wire

[rtl/sts_back.sv]
// Back end: per-neuron time queues, add execution and tick scan.
`default_nettype none
module sts_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       req_valid_i,
  input  wire sts_pkg::sts_req_t          req_i,
  output logic                            req_pop_o,
  input  wire logic [15:0]                group_i,
  output logic                            result_valid_o,
  output logic [1:0]                      kind_o,
  output logic [15:0]                     group_out_o,
  output logic [3:0]                      fired_neuron_o,
  output logic [1:0]                      status_o,
  output logic [5:0]                      fire_count_o,
  output logic                            last_item_o
);
  import sts_pkg::*;

  localparam int SUM_W = QC_W + 1;

  logic [TIME_W-1:0] store_q [STORE_DEPTH];
  logic [QH_W-1:0]   head_q [NEURON_COUNT];
  logic [QH_W-1:0]   head_d [NEURON_COUNT];
  logic [QC_W-1:0]   count_q [NEURON_COUNT];
  logic [QC_W-1:0]   count_d [NEURON_COUNT];

  sts_state_e        state_q, state_d;
  logic [NIDX_W-1:0] cur_q, cur_d;
  logic [TIME_W-1:0] tick_q, tick_d;
  logic [FIRE_W-1:0] fires_q, fires_d;

  logic              out_valid_q, out_valid_d;
  sts_kind_e         out_kind_q, out_kind_d;
  logic [IDX_W-1:0]  out_neuron_q, out_neuron_d;
  sts_status_e       out_status_q, out_status_d;
  logic [FIRE_W-1:0] out_count_q, out_count_d;
  logic              out_last_q, out_last_d;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [NIDX_W-1:0] add_n;
  logic [SUM_W-1:0]  slot_sum;
  logic [QH_W-1:0]   slot;
  logic [ADDR_W-1:0] rd_addr;
  logic [TIME_W-1:0] head_time;
  logic              due;

  assign add_n     = req_i.idx[NIDX_W-1:0];
  assign rd_addr   = ADDR_W'(cur_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[cur_q]);
  assign head_time = store_q[rd_addr];
  assign due       = (count_q[cur_q] != '0) && (head_time <= tick_q);

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    tick_d       = tick_q;
    fires_d      = fires_q;
    head_d       = head_q;
    count_d      = count_q;
    req_pop_o    = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    slot_sum     = SUM_W'(head_q[add_n]) + SUM_W'(count_q[add_n]);
    if (slot_sum >= SUM_W'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - SUM_W'(QUEUE_DEPTH);
    end
    slot         = slot_sum[QH_W-1:0];
    out_valid_d  = 1'b0;
    out_kind_d   = KIND_ACK;
    out_neuron_d = '0;
    out_status_d = STAT_OK;
    out_count_d  = '0;
    out_last_d   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          if (req_i.cmd == CMD_ADD) begin
            out_valid_d  = 1'b1;
            out_kind_d   = KIND_ACK;
            out_neuron_d = req_i.idx;
            out_last_d   = 1'b1;
            if (!req_i.in_range) begin
              out_status_d = STAT_RANGE;
            end else if (count_q[add_n] == QC_W'(QUEUE_DEPTH)) begin
              out_status_d = STAT_FULL;
            end else begin
              wr_en          = 1'b1;
              wr_addr        = ADDR_W'(add_n) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
              count_d[add_n] = count_q[add_n] + QC_W'(1);
            end
          end else begin
            tick_d  = req_i.time_val;
            cur_d   = '0;
            fires_d = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (due) begin
          out_valid_d    = 1'b1;
          out_kind_d     = KIND_FIRE;
          out_neuron_d   = IDX_W'(cur_q);
          fires_d        = fires_q + FIRE_W'(1);
          count_d[cur_q] = count_q[cur_q] - QC_W'(1);
          if (head_q[cur_q] == QH_W'(QUEUE_DEPTH - 1)) begin
            head_d[cur_q] = '0;
          end else begin
            head_d[cur_q] = head_q[cur_q] + QH_W'(1);
          end
        end else if (cur_q == NIDX_W'(NEURON_COUNT - 1)) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_DONE;
          out_count_d = fires_q;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          cur_d = cur_q + NIDX_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      fires_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NEURON_COUNT; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      fires_q     <= fires_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tick_q       <= tick_d;
    out_kind_q   <= out_kind_d;
    out_neuron_q <= out_neuron_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
    if (wr_en) begin
      store_q[wr_addr] <= req_i.time_val;
    end
  end

  assign result_valid_o = out_valid_q;
  assign kind_o         = out_kind_q;
  assign group_out_o    = group_i;
  assign fired_neuron_o = out_neuron_q;
  assign status_o       = out_status_q;
  assign fire_count_o   = out_count_q;
  assign last_item_o    = out_last_q;

endmodule
`default_nettype wire

[tb/tb_spike_time_scheduler_top.sv]
// Testbench for the spike time scheduler: predicts the queue behavior and checks every result.
`timescale 1ns / 1ps

module tb_spike_time_scheduler_top;
  import sts_pkg::*;

  localparam logic [2:0] GROUP_ADDR  = 3'd0;
  localparam logic [2:0] UNUSED_ADDR = 3'd4;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         PHASES      = 4;
  localparam int         PHASE_ITEMS = 32;

  typedef struct {
    sts_kind_e             kind;
    logic [GROUP_W-1:0]    group;
    logic [IDX_W-1:0]      neuron;
    sts_status_e           status;
    logic [FIRE_W-1:0]     count;
    logic                  last;
  } spike_result_t;

  class fire_time_predictor;
    logic [TIME_W-1:0]  times [NEURON_COUNT][QUEUE_DEPTH];
    int unsigned        head [NEURON_COUNT];
    int unsigned        fill [NEURON_COUNT];
    logic [GROUP_W-1:0] group_id;
    spike_result_t      pending [$];
    int                 errors;

    function void queue_result(sts_kind_e kind, logic [IDX_W-1:0] neuron,
                               sts_status_e status, logic [FIRE_W-1:0] count, logic last);
      spike_result_t r;
      r.kind   = kind;
      r.group  = group_id;
      r.neuron = neuron;
      r.status = status;
      r.count  = count;
      r.last   = last;
      pending.insert(pending.size(), r);
    endfunction

    function void note_request(sts_cmd_e cmd, logic [IDX_W-1:0] idx, logic [TIME_W-1:0] tv);
      sts_status_e status;
      int unsigned fires;
      int unsigned slot;
      if (cmd == CMD_ADD) begin
        status = STAT_OK;
        if (idx >= NEURON_COUNT) begin
          status = STAT_RANGE;
        end else if (fill[idx] >= QUEUE_DEPTH) begin
          status = STAT_FULL;
        end else begin
          slot = (head[idx] + fill[idx]) % QUEUE_DEPTH;
          times[idx][slot] = tv;
          fill[idx]++;
        end
        queue_result(KIND_ACK, idx, status, '0, 1'b1);
      end else begin
        fires = 0;
        for (int n = 0; n < NEURON_COUNT; n++) begin
          // pop due heads in FIFO order; a later head never passes an earlier one
          while (fill[n] > 0 && times[n][head[n]] <= tv) begin
            queue_result(KIND_FIRE, IDX_W'(n), STAT_OK, '0, 1'b0);
            fires++;
            head[n] = (head[n] + 1) % QUEUE_DEPTH;
            fill[n]--;
          end
        end
        queue_result(KIND_DONE, '0, STAT_OK, FIRE_W'(fires), 1'b1);
      end
    endfunction

    function void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(logic [KIND_W-1:0] kind, logic [GROUP_W-1:0] group,
                               logic [IDX_W-1:0] neuron, logic [STAT_W-1:0] status,
                               logic [FIRE_W-1:0] count, logic last);
      spike_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none actual kind %0h neuron %0h",
                 $time, kind, neuron);
        errors++;
        return;
      end
      e = pending[0];
      pending.delete(0);
      check_field("kind", 32'(e.kind), 32'(kind));
      check_field("group_out", 32'(e.group), 32'(group));
      check_field("fired_neuron", 32'(e.neuron), 32'(neuron));
      check_field("status", 32'(e.status), 32'(status));
      check_field("fire_count", 32'(e.count), 32'(count));
      check_field("last_item", 32'(e.last), 32'(last));
    endfunction
  endclass

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                start          = 1'b0;
  logic                command_i      = 1'b0;
  logic [IDX_W-1:0]    neuron_index_i = '0;
  logic [TIME_W-1:0]   time_value_i   = '0;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [2:0]          paddr          = '0;
  logic [31:0]         pwdata         = '0;
  logic                busy;
  logic                result_valid_o;
  logic [KIND_W-1:0]   kind_o;
  logic [GROUP_W-1:0]  group_out_o;
  logic [IDX_W-1:0]    fired_neuron_o;
  logic [STAT_W-1:0]   status_o;
  logic [FIRE_W-1:0]   fire_count_o;
  logic                last_item_o;
  logic [31:0]         prdata;
  logic                pready;

  fire_time_predictor sb = new;
  int                 cycles = 0;

  spike_time_scheduler_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .neuron_index_i (neuron_index_i),
    .time_value_i   (time_value_i),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .group_out_o    (group_out_o),
    .fired_neuron_o (fired_neuron_o),
    .status_o       (status_o),
    .fire_count_o   (fire_count_o),
    .last_item_o    (last_item_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result(kind_o, group_out_o, fired_neuron_o, status_o, fire_count_o,
                      last_item_o);
    end
  end

  // caller sits at a rising edge; start is left high so back-to-back requests stay seamless
  task automatic send_request(sts_cmd_e cmd, logic [IDX_W-1:0] idx, logic [TIME_W-1:0] tv);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    command_i      <= cmd;
    neuron_index_i <= idx;
    time_value_i   <= tv;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(cmd, idx, tv);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] data,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_register(logic [2:0] addr, logic [31:0] data);
    logic [31:0] rdata;
    apb_access(1'b1, addr, data, rdata);
    if (addr == GROUP_ADDR) sb.group_id = data[GROUP_W-1:0];
    apb_access(1'b0, GROUP_ADDR, '0, rdata);
    sb.check_field("group readback", {16'h0, sb.group_id}, rdata);
  endtask

  initial begin
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] tv;
    logic [IDX_W-1:0]  idx;
    sts_cmd_e          cmd;
    int                roll;

    sb.group_id = '0;
    sb.errors   = 0;
    for (int n = 0; n < NEURON_COUNT; n++) begin
      sb.head[n] = 0;
      sb.fill[n] = 0;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_register(GROUP_ADDR, 32'h0000_FFFF);
    write_register(UNUSED_ADDR, 32'h0000_1234);

    send_request(CMD_TICK, 4'd0, 32'd0);
    send_request(CMD_ADD, 4'd0, 32'd0);
    send_request(CMD_ADD, 4'd0, 32'hFFFF_FFFF);
    send_request(CMD_ADD, 4'd0, 32'd5);
    send_request(CMD_ADD, 4'd0, 32'd7);
    send_request(CMD_ADD, 4'd0, 32'd1);
    send_request(CMD_ADD, 4'd8, 32'd9);
    send_request(CMD_ADD, 4'd15, 32'hAAAA_AAAA);
    send_request(CMD_ADD, 4'd7, 32'd3);
    send_request(CMD_ADD, 4'd3, 32'd0);
    send_request(CMD_TICK, 4'd15, 32'd0);
    send_request(CMD_TICK, 4'd0, 32'd6);
    send_request(CMD_TICK, 4'd9, 32'hFFFF_FFFF);
    send_request(CMD_ADD, 4'd5, 32'h5555_5555);
    send_request(CMD_TICK, 4'd0, 32'h5555_5554);
    send_request(CMD_TICK, 4'd0, 32'h5555_5555);
    send_request(CMD_TICK, 4'd0, 32'hFFFF_FFFF);
    wait_for_results();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_register(GROUP_ADDR, 32'h0);
        3: write_register(GROUP_ADDR, 32'hFFFF_0001);
        default: write_register(GROUP_ADDR, $urandom);
      endcase
      now = (p == 3) ? 32'hFFFF_FF80 : $urandom_range(0, 1000);

      if (p == 2) begin
        // every queue filled, one add refused, then a single tick drains all of them
        send_request(CMD_TICK, 4'd0, 32'hFFFF_FFFF);
        for (int n = 0; n < NEURON_COUNT; n++) begin
          for (int k = 0; k < QUEUE_DEPTH; k++) begin
            send_request(CMD_ADD, IDX_W'(n), now + $urandom_range(0, 50));
          end
        end
        send_request(CMD_ADD, IDX_W'($urandom_range(0, NEURON_COUNT - 1)), $urandom);
        send_request(CMD_TICK, 4'd0, 32'hFFFF_FFFF);
      end

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
          cmd = CMD_TICK;
          now = now + $urandom_range(0, 24);
          idx = IDX_W'($urandom_range(0, 15));
          if (roll < 2) tv = '1;
          else if (roll < 5) tv = $urandom;
          else tv = now;
        end else begin
          cmd = CMD_ADD;
          idx = (roll < 35) ? IDX_W'($urandom_range(NEURON_COUNT, 15))
                            : IDX_W'($urandom_range(0, NEURON_COUNT - 1));
          tv  = (roll >= 90) ? $urandom : now + $urandom_range(0, 40);
        end
        send_request(cmd, idx, tv);
      end
      wait_for_results();
    end

    repeat (4 * NEURON_COUNT) @(posedge clk_i);
    while (sb.pending.size() != 0) begin
      $display("%0t: missing result, expected kind %0h neuron %0h actual none",
               $time, sb.pending[0].kind, sb.pending[0].neuron);
      sb.pending.delete(0);
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
